// ===== design/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and the arctangent table for the quaternion to
// ZYX Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int unsigned NumW  = 33;   // atan2 operand width
  localparam int unsigned AngW  = 34;   // angle width, 2^-30 rad units
  localparam int unsigned CrdW  = 37;   // CORDIC vector width
  localparam int unsigned RemW  = 62;   // square-root remainder width
  localparam int unsigned SqrtSteps = 31;

  localparam logic signed [NumW-1:0] HalfQ30 = 33'sd536870912;
  localparam logic signed [33:0]     OneQ30  = 34'sd1073741824;
  localparam logic signed [AngW-1:0] AngPi   = 34'sd3373259426;
  localparam logic signed [17:0]     FullLim = 18'sd25736;
  localparam logic signed [17:0]     HalfLim = 18'sd12868;

  // Item handed from the front end to the CORDIC back end
  typedef struct packed {
    logic signed [NumW-1:0] roll_num;
    logic signed [NumW-1:0] roll_den;
    logic signed [NumW-1:0] yaw_num;
    logic signed [NumW-1:0] yaw_den;
    logic signed [31:0]     pitch_num;
    logic        [30:0]     pitch_den;
    logic                   clamped;
  } q2e_item_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic [29:0] atan_f(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314857;
      1:  r = 30'd497837829;
      2:  r = 30'd263043837;
      3:  r = 30'd133525159;
      4:  r = 30'd67021687;
      5:  r = 30'd33543516;
      6:  r = 30'd16775851;
      7:  r = 30'd8388437;
      8:  r = 30'd4194283;
      9:  r = 30'd2097149;
      10: r = 30'd1048576;
      11: r = 30'd524288;
      12: r = 30'd262144;
      13: r = 30'd131072;
      14: r = 30'd65536;
      15: r = 30'd32768;
      16: r = 30'd16384;
      17: r = 30'd8192;
      18: r = 30'd4096;
      19: r = 30'd2048;
      20: r = 30'd1024;
      21: r = 30'd512;
      22: r = 30'd256;
      23: r = 30'd128;
      24: r = 30'd64;
      25: r = 30'd32;
      26: r = 30'd16;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      30: r = 30'd1;
      31: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Round 2^-30 rad to Q3.13 half up, then saturate to +-lim
  function automatic logic signed [17:0] q13_f(input logic signed [AngW-1:0] ang,
                                               input logic signed [17:0] lim);
    logic signed [AngW:0] t;
    logic signed [17:0]   r;
    t = {ang[AngW-1], ang} + 35'sd65536;
    r = 18'(t >>> 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

// ===== design/quaternion_to_euler_angles.sv =====
// Path: input beat through 3 product/sum/square stages, 31 square-root stages,
//   the queue and the CORDIC lanes to the output register.
// Throughput: one quaternion per cycle while the queue and the output do not stall; every stage is a pipeline register.
// Reset: asynchronous active-low rst_ni clears all valid bits and the queue.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q1.15 quaternion to ZYX roll and yaw in Q3.13 and pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);
  import q2e_pkg::*;

  localparam int unsigned NSteps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic      push, full, pop, empty;
  q2e_item_t f_item, b_item;

  q2e_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .push_o(push), .full_i(full), .item_o(f_item)
  );

  q2e_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_item), .full_o(full),
    .pop_i(pop), .data_o(b_item), .empty_o(empty)
  );

  q2e_back #(.NSteps(NSteps)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(b_item), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .roll_angle_o, .pitch_angle_o, .yaw_angle_o, .pitch_clamped_o
  );

endmodule

// ===== design/q2e_front.sv =====
// ----------------------------------------------------------------------------
// q2e_front
// Forms the atan2 operands: products, sums, pitch argument clamp and a
// pipelined integer square root for the pitch cosine.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                push_o,
  input  logic                full_i,
  output q2e_pkg::q2e_item_t  item_o
);
  import q2e_pkg::*;

  localparam int unsigned NS = SqrtSteps;

  logic en;
  logic v1_q, v2_q;
  logic iv_q [0:NS];

  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_xy_q, p_wz_q, p_zz_q;
  logic signed [31:0] p_xz_q, p_wy_q;

  q2e_item_t          s2_d, s2_q;
  logic signed [33:0] a_full;
  logic signed [32:0] a_diff;

  q2e_item_t          it_q  [0:NS];
  logic [RemW-1:0]    rem_q [0:NS];
  logic [RemW-1:0]    res_q [0:NS];
  logic signed [63:0] sq;

  // Whole pipeline advances together; hold while the last stage is valid and the queue is full
  assign en         = !iv_q[NS] || !full_i;
  assign in_ready_o = en;
  assign push_o     = iv_q[NS] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 0; k <= NS; k++) iv_q[k] <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      iv_q[0] <= v2_q;
      for (int k = 1; k <= NS; k++) iv_q[k] <= iv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= quat_w_i * quat_x_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_xx_q <= quat_x_i * quat_x_i;
      p_yy_q <= quat_y_i * quat_y_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_wz_q <= quat_w_i * quat_z_i;
      p_zz_q <= quat_z_i * quat_z_i;
      p_xz_q <= quat_x_i * quat_z_i;
      p_wy_q <= quat_w_i * quat_y_i;
    end
  end

  always_comb begin
    s2_d.roll_num = 33'(p_yz_q) + 33'(p_wx_q);
    s2_d.roll_den = HalfQ30 - (33'(p_xx_q) + 33'(p_yy_q));
    s2_d.yaw_num  = 33'(p_xy_q) + 33'(p_wz_q);
    s2_d.yaw_den  = HalfQ30 - (33'(p_yy_q) + 33'(p_zz_q));
    a_diff        = 33'(p_xz_q) - 33'(p_wy_q);
    a_full        = -(34'(a_diff) <<< 1);
    s2_d.clamped  = 1'b0;
    if (a_full > OneQ30) begin
      a_full       = OneQ30;
      s2_d.clamped = 1'b1;
    end
    if (a_full < -OneQ30) begin
      a_full       = -OneQ30;
      s2_d.clamped = 1'b1;
    end
    s2_d.pitch_num = a_full[31:0];
    s2_d.pitch_den = '0;
  end

  assign sq = s2_q.pitch_num * s2_q.pitch_num;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s2_d;
      it_q[0]  <= s2_q;
      rem_q[0] <= (RemW'(1) << 60) - RemW'(sq[60:0]);
      res_q[0] <= '0;
    end
  end

  // One result bit per stage, bit weight 2^(60-2k)
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [RemW-1:0] Bit = RemW'(1) << (60 - 2 * k);
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = res_q[k] + Bit;
    assign ge    = rem_q[k] >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[k+1]  <= it_q[k];
        rem_q[k+1] <= ge ? rem_q[k] - trial : rem_q[k];
        res_q[k+1] <= ge ? (res_q[k] >> 1) + Bit : res_q[k] >> 1;
      end
    end
  end

  always_comb begin
    item_o           = it_q[NS];
    item_o.pitch_den = res_q[NS][30:0];
  end

endmodule

// ===== design/q2e_fifo.sv =====
// ----------------------------------------------------------------------------
// q2e_fifo
// Short queue between the operand front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module q2e_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  q2e_pkg::q2e_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output q2e_pkg::q2e_item_t data_o,
  output logic               empty_o
);
  import q2e_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);

  q2e_item_t     mem_q [0:Depth-1];
  q2e_item_t     data_q;
  logic [AW-1:0] wr_q, rd_q, rd_d;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rd_d    = rd_q + AW'(pop_i);
  assign data_o  = data_q;

  // Keep the head entry registered; bypass a beat written straight to the head
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
    data_q <= (push_i && (wr_q == rd_d)) ? data_i : mem_q[rd_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      rd_q  <= rd_d;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count out of range");
`endif

endmodule

// ===== design/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2, one iteration per stage.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int unsigned NSteps = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [q2e_pkg::NumW-1:0]      num_i,
  input  logic signed [q2e_pkg::NumW-1:0]      den_i,
  output logic signed [q2e_pkg::AngW-1:0]      ang_o
);
  import q2e_pkg::*;

  logic signed [CrdW-1:0] x_q [0:NSteps];
  logic signed [CrdW-1:0] y_q [0:NSteps];
  logic signed [AngW-1:0] a_q [0:NSteps];
  logic                   z_q [0:NSteps];

  // Turn by +-pi into the right half plane first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (num_i == '0) && (den_i == '0);
      if (den_i < 0) begin
        x_q[0] <= -CrdW'(den_i);
        y_q[0] <= -CrdW'(num_i);
        a_q[0] <= (num_i >= 0) ? AngPi : -AngPi;
      end else begin
        x_q[0] <= CrdW'(den_i);
        y_q[0] <= CrdW'(num_i);
        a_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSteps; i++) begin : g_step
    localparam logic signed [AngW-1:0] Atan = AngW'(atan_f(i));
    logic signed [CrdW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1] <= z_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          a_q[i+1] <= a_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          a_q[i+1] <= a_q[i] - Atan;
        end
      end
    end
  end

  // Both operands zero: angle is zero
  assign ang_o = z_q[NSteps] ? '0 : a_q[NSteps];

endmodule

// ===== design/q2e_back.sv =====
// ----------------------------------------------------------------------------
// q2e_back
// Three CORDIC lanes for roll, pitch and yaw, rounding and output register.
// ----------------------------------------------------------------------------
module q2e_back #(
  parameter int unsigned NSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  q2e_pkg::q2e_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);
  import q2e_pkg::*;

  logic en;
  logic vb_q [0:NSteps];
  logic cf_q [0:NSteps];
  logic ov_q;
  logic signed [AngW-1:0] roll_ang, pitch_ang, yaw_ang;
  logic signed [17:0]     roll_r, pitch_r, yaw_r;

  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && !empty_i;

  q2e_cordic #(.NSteps(NSteps)) u_roll (
    .clk_i, .en_i(en), .num_i(item_i.roll_num), .den_i(item_i.roll_den), .ang_o(roll_ang)
  );
  q2e_cordic #(.NSteps(NSteps)) u_pitch (
    .clk_i, .en_i(en), .num_i(NumW'(item_i.pitch_num)),
    .den_i(NumW'({1'b0, item_i.pitch_den})), .ang_o(pitch_ang)
  );
  q2e_cordic #(.NSteps(NSteps)) u_yaw (
    .clk_i, .en_i(en), .num_i(item_i.yaw_num), .den_i(item_i.yaw_den), .ang_o(yaw_ang)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NSteps; k++) vb_q[k] <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      vb_q[0] <= !empty_i;
      for (int k = 1; k <= NSteps; k++) vb_q[k] <= vb_q[k-1];
      ov_q <= vb_q[NSteps];
    end
  end

  assign roll_r  = q13_f(roll_ang, FullLim);
  assign pitch_r = q13_f(pitch_ang, HalfLim);
  assign yaw_r   = q13_f(yaw_ang, FullLim);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cf_q[0] <= item_i.clamped;
      for (int k = 1; k <= NSteps; k++) cf_q[k] <= cf_q[k-1];
      roll_angle_o    <= roll_r[15:0];
      pitch_angle_o   <= pitch_r[14:0];
      yaw_angle_o     <= yaw_r[15:0];
      pitch_clamped_o <= cf_q[NSteps];
    end
  end

  assign out_valid_o = ov_q;

endmodule
